### rtl/arq_sender_window_assert.svh
// assertion macros used by the checker file of the arq sender window
`ifndef ARQ_SENDER_WINDOW_ASSERT_SVH
`define ARQ_SENDER_WINDOW_ASSERT_SVH

// clocked check that is switched off while reset is high
`define ARQSW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("arq_sender_window check failed");

// clocked check that also holds during reset
`define ARQSW_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("arq_sender_window check failed");

`endif

### rtl/arqsw_pkg.sv
// package of the arq sender window: sizes, codes and item types
`default_nettype none

package arqsw_pkg;

   localparam int WINDOW_SLOTS = 16;
   localparam int IDX_W        = $clog2(WINDOW_SLOTS);
   localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);

   localparam int SLOT_FIELD_W   = 4;
   localparam int FLIGHT_FIELD_W = 5;
   localparam int ID_W           = 32;
   localparam int TIME_W         = 32;
   localparam int TIMEOUT_W      = 16;
   localparam int RETRY_W        = 4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef logic [IDX_W-1:0]     slot_idx_type;
   typedef logic [CNT_W-1:0]     slot_cnt_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_TIMEOUT_MS  = 1'b0;
   localparam csr_idx_type CSR_RETRY_LIMIT = 1'b1;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
   localparam logic [RETRY_W-1:0]   RETRY_RESET   = 4'd6;
   localparam logic [RETRY_W-1:0]   RETRY_MAX     = 4'd15;

   localparam logic [1:0] REQ_SEND = 2'd0;
   localparam logic [1:0] REQ_ACK  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   typedef enum logic [2:0] {
      ST_SENT        = 3'd0,
      ST_FULL        = 3'd1,
      ST_ACK_OK      = 3'd2,
      ST_ACK_UNKNOWN = 3'd3,
      ST_RETX        = 3'd4,
      ST_IDLE        = 3'd5,
      ST_DEAD        = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_ACK_SCAN,
      SEQ_SLIDE,
      SEQ_TICK_SCAN,
      SEQ_DELIVER
   } seq_state_type;

   typedef struct packed {
      logic [1:0]      req_type;
      logic [ID_W-1:0] seq_id;
   } req_item_type;

   typedef struct packed {
      status_type                status;
      logic [ID_W-1:0]           tx_id;
      logic [SLOT_FIELD_W-1:0]   slot_index;
      logic [FLIGHT_FIELD_W-1:0] in_flight;
   } rsp_item_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_ms;
      logic [RETRY_W-1:0]   retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [ID_W-1:0]    packet_id;
      logic [TIME_W-1:0]  sent_time;
      logic [RETRY_W-1:0] retries;
   } slot_entry_type;

   typedef struct packed {
      logic           rd_en;
      slot_idx_type   rd_addr;
      logic           wr_en;
      slot_idx_type   wr_addr;
      slot_entry_type wr_data;
   } ram_req_type;

   typedef struct packed {
      logic start;
      logic res_take;
   } seq_ctrl_type;

   typedef struct packed {
      logic ready;
      logic res_valid;
   } seq_status_type;

endpackage

`default_nettype wire

### rtl/arqsw_slot_ram.sv
// slot memory: packet id, send time and retry count per slot, registered read
`default_nettype none

module arqsw_slot_ram (
   input  wire                    clock,
   input  arqsw_pkg::ram_req_type ram_req,
   output arqsw_pkg::slot_entry_type rd_data
);

   arqsw_pkg::slot_entry_type mem [arqsw_pkg::WINDOW_SLOTS];
   arqsw_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/arqsw_seq.sv
// sequencer: window pointers, valid bits and the slot scan over the slot memory
`default_nettype none

module arqsw_seq (
   input  wire                        clock,
   input  wire                        reset,
   input  arqsw_pkg::cfg_type         cfg,
   input  arqsw_pkg::seq_ctrl_type    ctrl,
   input  arqsw_pkg::req_item_type    item,
   output arqsw_pkg::seq_status_type  status,
   output arqsw_pkg::rsp_item_type    res,
   output arqsw_pkg::ram_req_type     ram_req,
   input  arqsw_pkg::slot_entry_type  ram_q
);

   localparam int SUM_W = arqsw_pkg::CNT_W + 1;

   function automatic arqsw_pkg::slot_idx_type next_slot(input arqsw_pkg::slot_idx_type i);
      if (i == arqsw_pkg::slot_idx_type'(arqsw_pkg::WINDOW_SLOTS - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   arqsw_pkg::seq_state_type state_ff, state_in;
   arqsw_pkg::req_item_type  item_ff, item_in;
   arqsw_pkg::slot_idx_type  head_ff, head_in;
   arqsw_pkg::slot_idx_type  tail_ff, tail_in;
   arqsw_pkg::slot_cnt_type  count_ff, count_in;
   logic [arqsw_pkg::TIME_W-1:0] now_ff, now_in;
   logic [arqsw_pkg::WINDOW_SLOTS-1:0] valid_ff, valid_in;
   arqsw_pkg::slot_cnt_type  issue_ff, issue_in;
   logic                     pend_ff, pend_in;
   arqsw_pkg::slot_idx_type  pend_idx_ff, pend_idx_in;
   arqsw_pkg::rsp_item_type  res_ff, res_in;

   logic [SUM_W-1:0]         tick_sum;
   arqsw_pkg::slot_idx_type  scan_addr;
   arqsw_pkg::slot_idx_type  vidx;
   logic                     v_sel;
   logic [arqsw_pkg::TIME_W-1:0] age;
   logic                     scan_done;

   // slot address of the next scan step: from zero for an ack, from the tail for a tick
   always_comb begin
      tick_sum = SUM_W'(tail_ff) + SUM_W'(issue_ff);
      if (tick_sum >= SUM_W'(arqsw_pkg::WINDOW_SLOTS)) begin
         tick_sum = tick_sum - SUM_W'(arqsw_pkg::WINDOW_SLOTS);
      end
      if (state_ff == arqsw_pkg::SEQ_TICK_SCAN) begin
         scan_addr = arqsw_pkg::slot_idx_type'(tick_sum);
      end else begin
         scan_addr = issue_ff[arqsw_pkg::IDX_W-1:0];
      end
      vidx  = (state_ff == arqsw_pkg::SEQ_SLIDE) ? tail_ff : scan_addr;
      v_sel = valid_ff[vidx];
      age   = now_ff - ram_q.sent_time;
      scan_done = (issue_ff == arqsw_pkg::slot_cnt_type'(arqsw_pkg::WINDOW_SLOTS));
   end

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      now_in      = now_ff;
      valid_in    = valid_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      res_in      = res_ff;
      ram_req     = '0;
      ram_req.rd_addr = scan_addr;

      unique case (state_ff)
         arqsw_pkg::SEQ_IDLE: begin
            if (ctrl.start) begin
               item_in  = item;
               issue_in = '0;
               priority case (item.req_type)
                  arqsw_pkg::REQ_ACK: begin
                     state_in = arqsw_pkg::SEQ_ACK_SCAN;
                  end
                  arqsw_pkg::REQ_TICK: begin
                     now_in   = now_ff + 1'b1;
                     state_in = arqsw_pkg::SEQ_TICK_SCAN;
                  end
                  default: begin
                     state_in = arqsw_pkg::SEQ_EXEC;
                  end
               endcase
            end
         end

         arqsw_pkg::SEQ_EXEC: begin
            res_in.status     = arqsw_pkg::ST_IDLE;
            res_in.tx_id      = '0;
            res_in.slot_index = '0;
            res_in.in_flight  = arqsw_pkg::FLIGHT_FIELD_W'(count_ff);
            if (item_ff.req_type == arqsw_pkg::REQ_SEND) begin
               res_in.slot_index = arqsw_pkg::SLOT_FIELD_W'(head_ff);
               if (count_ff == arqsw_pkg::slot_cnt_type'(arqsw_pkg::WINDOW_SLOTS)) begin
                  res_in.status = arqsw_pkg::ST_FULL;
               end else begin
                  ram_req.wr_en             = 1'b1;
                  ram_req.wr_addr           = head_ff;
                  ram_req.wr_data.packet_id = item_ff.seq_id;
                  ram_req.wr_data.sent_time = now_ff;
                  ram_req.wr_data.retries   = '0;
                  valid_in[head_ff]         = 1'b1;
                  head_in                   = next_slot(head_ff);
                  count_in                  = count_ff + 1'b1;
                  res_in.status             = arqsw_pkg::ST_SENT;
                  res_in.tx_id              = item_ff.seq_id;
                  res_in.in_flight          = arqsw_pkg::FLIGHT_FIELD_W'(count_ff + 1'b1);
               end
            end
            state_in = arqsw_pkg::SEQ_DELIVER;
         end

         arqsw_pkg::SEQ_ACK_SCAN: begin
            // compare the slot read last cycle while the next read goes out
            if (pend_ff && ram_q.packet_id == item_ff.seq_id) begin
               valid_in[pend_idx_ff] = 1'b0;
               res_in.status         = arqsw_pkg::ST_ACK_OK;
               res_in.tx_id          = '0;
               res_in.slot_index     = arqsw_pkg::SLOT_FIELD_W'(pend_idx_ff);
               state_in              = arqsw_pkg::SEQ_SLIDE;
            end else if (scan_done) begin
               res_in.status     = arqsw_pkg::ST_ACK_UNKNOWN;
               res_in.tx_id      = '0;
               res_in.slot_index = '0;
               res_in.in_flight  = arqsw_pkg::FLIGHT_FIELD_W'(count_ff);
               state_in          = arqsw_pkg::SEQ_DELIVER;
            end else begin
               ram_req.rd_en = 1'b1;
               pend_in       = v_sel;
               pend_idx_in   = scan_addr;
               issue_in      = issue_ff + 1'b1;
            end
         end

         arqsw_pkg::SEQ_SLIDE: begin
            // one cleared slot leaves the tail per cycle
            if (count_ff != '0 && !v_sel) begin
               tail_in  = next_slot(tail_ff);
               count_in = count_ff - 1'b1;
            end else begin
               res_in.in_flight = arqsw_pkg::FLIGHT_FIELD_W'(count_ff);
               state_in         = arqsw_pkg::SEQ_DELIVER;
            end
         end

         arqsw_pkg::SEQ_TICK_SCAN: begin
            res_in.in_flight = arqsw_pkg::FLIGHT_FIELD_W'(count_ff);
            res_in.tx_id     = '0;
            if (pend_ff && age > arqsw_pkg::TIME_W'(cfg.timeout_ms)) begin
               res_in.slot_index = arqsw_pkg::SLOT_FIELD_W'(pend_idx_ff);
               if (ram_q.retries > cfg.retry_limit) begin
                  res_in.status = arqsw_pkg::ST_DEAD;
               end else begin
                  ram_req.wr_en             = 1'b1;
                  ram_req.wr_addr           = pend_idx_ff;
                  ram_req.wr_data.packet_id = ram_q.packet_id;
                  ram_req.wr_data.sent_time = now_ff;
                  ram_req.wr_data.retries   = (ram_q.retries == arqsw_pkg::RETRY_MAX) ?
                                              arqsw_pkg::RETRY_MAX : ram_q.retries + 1'b1;
                  res_in.status             = arqsw_pkg::ST_RETX;
                  res_in.tx_id              = ram_q.packet_id;
               end
               state_in = arqsw_pkg::SEQ_DELIVER;
            end else if (scan_done) begin
               res_in.status     = arqsw_pkg::ST_IDLE;
               res_in.slot_index = '0;
               state_in          = arqsw_pkg::SEQ_DELIVER;
            end else begin
               ram_req.rd_en = 1'b1;
               pend_in       = v_sel;
               pend_idx_in   = scan_addr;
               issue_in      = issue_ff + 1'b1;
            end
         end

         arqsw_pkg::SEQ_DELIVER: begin
            if (ctrl.res_take) begin
               state_in = arqsw_pkg::SEQ_IDLE;
            end
         end

         default: begin
            state_in = arqsw_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arqsw_pkg::SEQ_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         now_ff   <= '0;
         valid_ff <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         now_ff   <= now_in;
         valid_ff <= valid_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pend_idx_ff <= pend_idx_in;
      res_ff      <= res_in;
   end

   assign status.ready     = (state_ff == arqsw_pkg::SEQ_IDLE);
   assign status.res_valid = (state_ff == arqsw_pkg::SEQ_DELIVER);
   assign res              = res_ff;

endmodule

`default_nettype wire

### rtl/arq_sender_window.sv
// top level of the selective-repeat arq sender window
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  arqsw_pkg::req_item_type
//   rsp       out         rsp_valid/rsp_stall  arqsw_pkg::rsp_item_type
//   csr       in          csr_wr_en            csr_index, csr_wr_data
//
// a tick scans the window from the tail, and an ack scans the slots and then slides the tail:
// the slot scan walks the slot memory one entry per cycle through its single read
// port, and the tail slide moves one slot per cycle
// one item is worked on at a time; the next item is taken while a result waits in
// the output register
// synchronous active-high reset clears pointers, valid bits and the clock; the
// slot memory needs no clearing since only data read from valid slots is ever used
// a stalled result holds the sequencer before it can finish the following item
`default_nettype none

module arq_sender_window (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  arqsw_pkg::req_item_type                 req_item,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output arqsw_pkg::rsp_item_type                 rsp_item,
   input  wire                                     csr_wr_en,
   input  wire [arqsw_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire [arqsw_pkg::CSR_DATA_W-1:0]         csr_wr_data
);

   arqsw_pkg::cfg_type         cfg_ff, cfg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   arqsw_pkg::rsp_item_type    rsp_item_ff;

   arqsw_pkg::seq_ctrl_type    seq_ctrl;
   arqsw_pkg::seq_status_type  seq_status;
   arqsw_pkg::rsp_item_type    seq_res;
   arqsw_pkg::ram_req_type     ram_req;
   arqsw_pkg::slot_entry_type  ram_q;
   logic                       out_free;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            arqsw_pkg::CSR_TIMEOUT_MS: begin
               cfg_in.timeout_ms = csr_wr_data[arqsw_pkg::TIMEOUT_W-1:0];
            end
            arqsw_pkg::CSR_RETRY_LIMIT: begin
               cfg_in.retry_limit = csr_wr_data[arqsw_pkg::RETRY_W-1:0];
            end
         endcase
      end
   end

   // input side: items are taken only while the sequencer is free
   assign req_stall      = !seq_status.ready;
   assign seq_ctrl.start = req_valid && !req_stall;

   // output register parts the sequencer from the result channel
   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign seq_ctrl.res_take = seq_status.res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_ctrl.res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms  <= arqsw_pkg::TIMEOUT_RESET;
         cfg_ff.retry_limit <= arqsw_pkg::RETRY_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctrl.res_take) begin
         rsp_item_ff <= seq_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // sequencer and slot memory; reads and writes of one slot never fall in the
   // same cycle, since a write only ends a scan or serves a send
   arqsw_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .ctrl    (seq_ctrl),
      .item    (req_item),
      .status  (seq_status),
      .res     (seq_res),
      .ram_req (ram_req),
      .ram_q   (ram_q)
   );

   arqsw_slot_ram u_slot_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_q)
   );

endmodule

`default_nettype wire

### rtl/arqsw_checker.sv
// port checker of the arq sender window and its bind
`default_nettype none

`include "arq_sender_window_assert.svh"

module arqsw_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     rsp_valid,
   input wire                     rsp_stall,
   input arqsw_pkg::rsp_item_type rsp_item
);

   // a stalled result holds
   `ARQSW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))

   // the window never reports more than its slots in flight
   `ARQSW_ASSERT(a_flight_max, clock, reset, rsp_valid |-> rsp_item.in_flight <= arqsw_pkg::WINDOW_SLOTS)

   // a refused send only happens with every slot taken and carries no id
   `ARQSW_ASSERT(a_full_window, clock, reset, rsp_valid && rsp_item.status == arqsw_pkg::ST_FULL |-> rsp_item.in_flight == arqsw_pkg::WINDOW_SLOTS && rsp_item.tx_id == '0)

   // a sent packet is in flight afterwards
   `ARQSW_ASSERT(a_sent_counts, clock, reset, rsp_valid && rsp_item.status == arqsw_pkg::ST_SENT |-> rsp_item.in_flight != '0)

endmodule

bind arq_sender_window arqsw_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire
